/* rtl/fsfe_pkg.sv */
// Shared types, codes and coefficients of the frame-store shape fill engine.
package fsfe_pkg;

  localparam int COORD_W = 24;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int OP_W    = 3;
  localparam int RAD_W   = 12;
  localparam int COLOR_W = 24;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUT    = 3'd1;
  localparam logic [OP_W-1:0] OP_CIRCLE = 3'd2;
  localparam logic [OP_W-1:0] OP_PIN    = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // Shape being scanned: the circle, the lower pin ellipse, the upper pin ellipse.
  localparam logic [1:0] KIND_CIRC = 2'd0;
  localparam logic [1:0] KIND_LO   = 2'd1;
  localparam logic [1:0] KIND_UP   = 2'd2;

  // Integer forms of the ellipse tests:
  //   lower: 121*dx^2 + 25*dy^2 <= 121*r^2
  //   upper: 225*dx^2 + (10*dy + 31*r)^2 <= 81*r^2
  localparam coord_t K_ONE      = 24'sd1;
  localparam coord_t K_LO_X     = 24'sd121;
  localparam coord_t K_LO_Y     = 24'sd25;
  localparam coord_t K_LO_R     = 24'sd121;
  localparam coord_t K_UP_X     = 24'sd225;
  localparam coord_t K_UP_R     = 24'sd81;
  localparam coord_t K_UP_SCALE = 24'sd10;
  localparam coord_t K_UP_OFS   = 24'sd31;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctrl_t;

endpackage

/* rtl/fsfe_mul.sv */
// Shared signed multiplier with a registered product.
module fsfe_mul (
  input  logic             clk_i,
  input  fsfe_pkg::coord_t a_i,
  input  fsfe_pkg::coord_t b_i,
  output fsfe_pkg::prod_t  prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= fsfe_pkg::prod_t'(a_i) * fsfe_pkg::prod_t'(b_i);
  end

endmodule

/* rtl/fsfe_store.sv */
// Single-port RGB frame memory with registered read data.
module fsfe_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                               clk_i,
  input  fsfe_pkg::store_ctrl_t              ctrl_i,
  input  logic [AW-1:0]                      addr_i,
  input  logic [fsfe_pkg::COLOR_W-1:0]       wdata_i,
  output logic [fsfe_pkg::COLOR_W-1:0]       rdata_o
);

  logic [fsfe_pkg::COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

/* rtl/framebuffer_shape_fill_engine_unit.sv */
// Top level of the frame-store shape fill engine: command sequencer and datapath.
//
// A command transfers at a rising edge where start_i is high and busy_o is low; busy_o
// then stays high until the single result, which is shown for exactly one cycle with
// done_o high and cannot be held off. Every command gives one result: read_*_o carry
// the addressed color for a read inside the frame and are zero otherwise, and
// inside_frame_o flags a put or read whose integer pixel lies in the frame. The frame
// memory has no reset value; issue a clear before reading. A clear writes every pixel,
// one memory write per cycle. A put or read outside the frame, an unused code and a
// pin of zero radius go straight to the result. A circle is one shape and a pin two;
// each shape whose clipped bounding box is not empty is scanned after a setup, row by
// row and pixel by pixel, and the single shared multiplier is used twice per pixel and
// four times per row. A circle of 16-pixel radius at 4 fractional bits, centred on a
// pixel and clear of the frame edges, scans a 35 by 35 box.
module framebuffer_shape_fill_engine_unit #(
  parameter int FRAME_WIDTH   = 256,
  parameter int FRAME_HEIGHT  = 256,
  parameter int FRACTION_BITS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  output logic                            done_o,
  input  logic [fsfe_pkg::OP_W-1:0]       op_i,
  input  logic signed [13:0]              pos_x_i,
  input  logic signed [13:0]              pos_y_i,
  input  logic [fsfe_pkg::RAD_W-1:0]      radius_i,
  input  logic [7:0]                      paint_red_i,
  input  logic [7:0]                      paint_green_i,
  input  logic [7:0]                      paint_blue_i,
  output logic [7:0]                      read_red_o,
  output logic [7:0]                      read_green_o,
  output logic [7:0]                      read_blue_o,
  output logic                            inside_frame_o
);

  localparam int PIX = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW  = $clog2(PIX);
  localparam int XW  = $clog2(FRAME_WIDTH);
  localparam int YW  = $clog2(FRAME_HEIGHT);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CLEAR  = 5'd1;
  localparam logic [4:0] ST_PT_MUL = 5'd2;
  localparam logic [4:0] ST_PT_ACC = 5'd3;
  localparam logic [4:0] ST_BOX    = 5'd4;
  localparam logic [4:0] ST_U0     = 5'd5;
  localparam logic [4:0] ST_U1     = 5'd6;
  localparam logic [4:0] ST_U2     = 5'd7;
  localparam logic [4:0] ST_U3     = 5'd8;
  localparam logic [4:0] ST_R0     = 5'd9;
  localparam logic [4:0] ST_R1     = 5'd10;
  localparam logic [4:0] ST_R2     = 5'd11;
  localparam logic [4:0] ST_R3     = 5'd12;
  localparam logic [4:0] ST_R4     = 5'd13;
  localparam logic [4:0] ST_P0     = 5'd14;
  localparam logic [4:0] ST_P1     = 5'd15;
  localparam logic [4:0] ST_P2     = 5'd16;
  localparam logic [4:0] ST_DONE   = 5'd17;

  // Control state.
  logic [4:0] state_q, state_d;
  logic [1:0] kind_q, kind_d;

  // Command and scan registers.
  logic [fsfe_pkg::OP_W-1:0]    op_q;
  logic                         inside_q;
  fsfe_pkg::coord_t             cx_q, cy_q, r_q;
  logic [fsfe_pkg::COLOR_W-1:0] color_q;
  logic [XW-1:0]                pi_q, i_q, ilo_q, ihi_q;
  logic [YW-1:0]                pj_q, j_q, jhi_q;
  logic [AW-1:0]                addr_q, base_q;
  fsfe_pkg::prod_t              rr_q, ydd_q;
  fsfe_pkg::coord_t             r31_q, dyv_q;

  // Shared multiplier.
  fsfe_pkg::coord_t mul_a, mul_b;
  fsfe_pkg::prod_t  prod;
  fsfe_pkg::coord_t prod_lo;

  // Frame memory port.
  fsfe_pkg::store_ctrl_t        store_ctrl;
  logic [AW-1:0]                store_addr;
  logic [fsfe_pkg::COLOR_W-1:0] store_wdata;
  logic [fsfe_pkg::COLOR_W-1:0] store_rdata;

  fsfe_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  fsfe_store #(
    .DEPTH (PIX),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .ctrl_i  (store_ctrl),
    .addr_i  (store_addr),
    .wdata_i (store_wdata),
    .rdata_o (store_rdata)
  );

  assign prod_lo = prod[fsfe_pkg::COORD_W-1:0];

  // Input decode for a command arriving now.
  fsfe_pkg::coord_t in_x, in_y, in_r, in_px, in_py;
  logic             in_inside;

  assign in_x  = fsfe_pkg::coord_t'(pos_x_i);
  assign in_y  = fsfe_pkg::coord_t'(pos_y_i);
  assign in_r  = fsfe_pkg::coord_t'(radius_i);
  assign in_px = in_x >>> FRACTION_BITS;
  assign in_py = in_y >>> FRACTION_BITS;
  assign in_inside = (in_px >= 0) && (in_px < fsfe_pkg::coord_t'(FRAME_WIDTH)) &&
                     (in_py >= 0) && (in_py < fsfe_pkg::coord_t'(FRAME_HEIGHT));

  // Bounding box of the current shape in pixels, clipped to the frame.
  fsfe_pkg::coord_t box_yl, box_yh;
  fsfe_pkg::coord_t ilo_raw, ihi_raw, jlo_raw, jhi_raw;
  fsfe_pkg::coord_t ilo_c, ihi_c, jlo_c, jhi_c;
  logic             box_empty;

  always_comb begin
    case (kind_q)
      fsfe_pkg::KIND_LO: begin
        box_yl = cy_q - ((r_q <<< 1) + r_q);
        box_yh = cy_q + ((r_q <<< 1) + r_q);
      end
      fsfe_pkg::KIND_UP: begin
        box_yl = cy_q + (r_q <<< 1);
        box_yh = cy_q + (r_q <<< 2);
      end
      default: begin
        box_yl = cy_q - r_q;
        box_yh = cy_q + r_q;
      end
    endcase
    ilo_raw = ((cx_q - r_q) >>> FRACTION_BITS) - fsfe_pkg::K_ONE;
    ihi_raw = ((cx_q + r_q) >>> FRACTION_BITS) + fsfe_pkg::K_ONE;
    jlo_raw = (box_yl >>> FRACTION_BITS) - fsfe_pkg::K_ONE;
    jhi_raw = (box_yh >>> FRACTION_BITS) + fsfe_pkg::K_ONE;
    ilo_c = (ilo_raw < 0) ? '0 : ilo_raw;
    jlo_c = (jlo_raw < 0) ? '0 : jlo_raw;
    ihi_c = (ihi_raw > fsfe_pkg::coord_t'(FRAME_WIDTH - 1)) ?
            fsfe_pkg::coord_t'(FRAME_WIDTH - 1) : ihi_raw;
    jhi_c = (jhi_raw > fsfe_pkg::coord_t'(FRAME_HEIGHT - 1)) ?
            fsfe_pkg::coord_t'(FRAME_HEIGHT - 1) : jhi_raw;
    box_empty = (ilo_c > ihi_c) || (jlo_c > jhi_c);
  end

  // Per-shape coefficients.
  fsfe_pkg::coord_t k_x, k_y, k_r, k_scale, dy_ofs;

  always_comb begin
    case (kind_q)
      fsfe_pkg::KIND_LO: begin
        k_x     = fsfe_pkg::K_LO_X;
        k_y     = fsfe_pkg::K_LO_Y;
        k_r     = fsfe_pkg::K_LO_R;
        k_scale = fsfe_pkg::K_ONE;
        dy_ofs  = '0;
      end
      fsfe_pkg::KIND_UP: begin
        k_x     = fsfe_pkg::K_UP_X;
        k_y     = fsfe_pkg::K_ONE;
        k_r     = fsfe_pkg::K_UP_R;
        k_scale = fsfe_pkg::K_UP_SCALE;
        dy_ofs  = r31_q;
      end
      default: begin
        k_x     = fsfe_pkg::K_ONE;
        k_y     = fsfe_pkg::K_ONE;
        k_r     = fsfe_pkg::K_ONE;
        k_scale = fsfe_pkg::K_ONE;
        dy_ofs  = '0;
      end
    endcase
  end

  // Offsets of the scanned pixel from the centre, in fractional units.
  fsfe_pkg::coord_t dx, dy_raw, row_flip, pt_flip;
  logic             hit;

  assign dx       = cx_q - (fsfe_pkg::coord_t'(i_q) <<< FRACTION_BITS);
  assign dy_raw   = cy_q - (fsfe_pkg::coord_t'(j_q) <<< FRACTION_BITS);
  assign row_flip = fsfe_pkg::coord_t'(FRAME_HEIGHT - 1) - fsfe_pkg::coord_t'(j_q);
  assign pt_flip  = fsfe_pkg::coord_t'(FRAME_HEIGHT - 1) - fsfe_pkg::coord_t'(pj_q);
  assign hit      = (ydd_q + prod) <= rr_q;

  // Multiplier operand selection by sequencer state; other states multiply zero by zero.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PT_MUL: begin
        mul_a = pt_flip;
        mul_b = fsfe_pkg::coord_t'(FRAME_WIDTH);
      end
      ST_U0: begin
        mul_a = k_r;
        mul_b = r_q;
      end
      ST_U1: begin
        mul_a = prod_lo;
        mul_b = r_q;
      end
      ST_U2: begin
        mul_a = fsfe_pkg::K_UP_OFS;
        mul_b = r_q;
      end
      ST_R0: begin
        mul_a = k_scale;
        mul_b = dy_raw;
      end
      ST_R1: begin
        mul_a = row_flip;
        mul_b = fsfe_pkg::coord_t'(FRAME_WIDTH);
      end
      ST_R2: begin
        mul_a = k_y;
        mul_b = dyv_q;
      end
      ST_R3: begin
        mul_a = prod_lo;
        mul_b = dyv_q;
      end
      ST_P0: begin
        mul_a = k_x;
        mul_b = dx;
      end
      ST_P1: begin
        mul_a = prod_lo;
        mul_b = dx;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Frame memory access.
  always_comb begin
    store_ctrl  = '0;
    store_addr  = '0;
    store_wdata = color_q;
    case (state_q)
      ST_CLEAR: begin
        store_ctrl.wr_en = 1'b1;
        store_addr       = addr_q;
        store_wdata      = fsfe_pkg::COLOR_WHITE;
      end
      ST_PT_ACC: begin
        store_ctrl.wr_en = (op_q == fsfe_pkg::OP_PUT);
        store_ctrl.rd_en = (op_q == fsfe_pkg::OP_READ);
        store_addr       = prod[AW-1:0] + AW'(pi_q);
      end
      ST_P2: begin
        store_ctrl.wr_en = hit;
        store_addr       = base_q + AW'(i_q);
      end
      default: begin
        store_ctrl = '0;
      end
    endcase
  end

  // Sequencer. A finished lower pin ellipse hands over to the upper one.
  logic shape_more;
  assign shape_more = (op_q == fsfe_pkg::OP_PIN) && (kind_q == fsfe_pkg::KIND_LO);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (op_i)
            fsfe_pkg::OP_CLEAR: state_d = ST_CLEAR;
            fsfe_pkg::OP_PUT,
            fsfe_pkg::OP_READ: state_d = in_inside ? ST_PT_MUL : ST_DONE;
            fsfe_pkg::OP_CIRCLE: begin
              kind_d  = fsfe_pkg::KIND_CIRC;
              state_d = ST_BOX;
            end
            fsfe_pkg::OP_PIN: begin
              kind_d  = fsfe_pkg::KIND_LO;
              state_d = (radius_i == '0) ? ST_DONE : ST_BOX;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (addr_q == AW'(PIX - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_PT_MUL: state_d = ST_PT_ACC;
      ST_PT_ACC: state_d = ST_DONE;
      ST_BOX: begin
        if (!box_empty) begin
          state_d = ST_U0;
        end else if (shape_more) begin
          kind_d = fsfe_pkg::KIND_UP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_U0: state_d = ST_U1;
      ST_U1: state_d = ST_U2;
      ST_U2: state_d = ST_U3;
      ST_U3: state_d = ST_R0;
      ST_R0: state_d = ST_R1;
      ST_R1: state_d = ST_R2;
      ST_R2: state_d = ST_R3;
      ST_R3: state_d = ST_R4;
      ST_R4: state_d = ST_P0;
      ST_P0: state_d = ST_P1;
      ST_P1: state_d = ST_P2;
      ST_P2: begin
        if (i_q != ihi_q) begin
          state_d = ST_P0;
        end else if (j_q != jhi_q) begin
          state_d = ST_R0;
        end else if (shape_more) begin
          kind_d  = fsfe_pkg::KIND_UP;
          state_d = ST_BOX;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= fsfe_pkg::KIND_CIRC;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_q     <= op_i;
          inside_q <= in_inside && (op_i inside {fsfe_pkg::OP_PUT, fsfe_pkg::OP_READ});
          cx_q     <= in_x;
          cy_q     <= in_y;
          r_q      <= in_r;
          color_q  <= {paint_red_i, paint_green_i, paint_blue_i};
          pi_q     <= in_px[XW-1:0];
          pj_q     <= in_py[YW-1:0];
          addr_q   <= '0;
        end
      end
      ST_CLEAR: addr_q <= addr_q + AW'(1);
      ST_BOX: begin
        ilo_q <= ilo_c[XW-1:0];
        ihi_q <= ihi_c[XW-1:0];
        j_q   <= jlo_c[YW-1:0];
        jhi_q <= jhi_c[YW-1:0];
      end
      ST_U2: rr_q  <= prod;
      ST_U3: r31_q <= prod_lo;
      ST_R1: dyv_q <= prod_lo + dy_ofs;
      ST_R2: base_q <= prod[AW-1:0];
      ST_R3: i_q <= ilo_q;
      ST_R4: ydd_q <= prod;
      ST_P2: begin
        if (i_q != ihi_q) begin
          i_q <= i_q + XW'(1);
        end else if (j_q != jhi_q) begin
          j_q <= j_q + YW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result.
  logic show_color;

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = (state_q == ST_DONE);
  assign show_color     = done_o && inside_q && (op_q == fsfe_pkg::OP_READ);
  assign inside_frame_o = done_o && inside_q;
  assign read_red_o     = show_color ? store_rdata[23:16] : 8'd0;
  assign read_green_o   = show_color ? store_rdata[15:8]  : 8'd0;
  assign read_blue_o    = show_color ? store_rdata[7:0]   : 8'd0;

  // Checks.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("command transfer did not make the engine busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("result strobe lasted more than one cycle");

  a_wr_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_ctrl.wr_en |-> (32'(store_addr) < 32'(PIX)))
    else $error("frame write outside the memory");

  a_inside_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_frame_o |-> ((op_q == fsfe_pkg::OP_PUT) || (op_q == fsfe_pkg::OP_READ)))
    else $error("inside flag raised for a command without a pixel coordinate");

  a_scan_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P2) |-> (i_q <= ihi_q) && (j_q <= jhi_q))
    else $error("scan left its bounding box");

endmodule
